### rtl/core/linear_probe_hash_table_defines.svh
// Assertion macros for the hash table RTL.
// They expect clk and rst_n in the scope where they are used.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication.
`define LPHT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht: assertion failed");

// Next-cycle implication.
`define LPHT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht: assertion failed");

`endif

### rtl/core/lpht_pkg.sv
`default_nettype none

package lpht_pkg;

  localparam int INDEX_BITS = 7;
  localparam int SLOT_COUNT = 1 << INDEX_BITS;
  localparam int WORD_W     = 32;
  localparam int ACT_W      = 8;
  localparam int STATUS_W   = 2;

  localparam logic [WORD_W-1:0] HASH_MULT = 32'd2654435761;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_HIT      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_MISS     = 2'd3;

  typedef logic [INDEX_BITS-1:0] slot_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0]        key;
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] arg;
  } slot_t;

endpackage

`default_nettype wire

### rtl/core/lpht_if.sv
`default_nettype none

interface lpht_in_if;
  import lpht_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [WORD_W-1:0]        key;
  logic [ACT_W-1:0]         action_code;
  logic signed [WORD_W-1:0] arg_value;

  modport source (output valid, op, key, action_code, arg_value, input ready);
  modport sink   (input valid, op, key, action_code, arg_value, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ACT_W-1:0]         found_action;
  logic signed [WORD_W-1:0] found_arg;

  modport source (output valid, status, found_action, found_arg, input ready);
  modport sink   (input valid, status, found_action, found_arg, output ready);
endinterface

`default_nettype wire

### rtl/core/lpht_ram.sv
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/linear_probe_hash_table.sv
// Open-addressing hash table, 128 slots, linear probing. The home slot is the top
// 7 bits of key * 2654435761 (mod 2^32). An insert stores key, action and argument
// in the first slot with action code zero, searching forward with wraparound, and
// reports full if every slot is taken; duplicate keys are not checked. A lookup
// walks occupied slots until it meets the key (hit), an empty slot or its start
// (miss). Occupancy is held in 128 valid flops cleared by reset, so the block is
// ready right after reset with no clearing pass. An item probes 1 to 128 slots. After
// acceptance the hash multiply is registered, the home-slot read is issued, and then
// one slot is probed per cycle from the single slot RAM read port; the final probe
// waits while an earlier result is still held by the receiver. Input is ready again
// in the same cycle as the result becomes valid. One item is worked on at a time;
// the result register lets the next transaction be accepted while a result waits.
`default_nettype none
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lpht_in_if.sink     in_ch,
  lpht_out_if.source  out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HASH  = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_PROBE = 2'd3;

  localparam slot_idx_t SLOT_MASK = '1;

  logic [1:0]               state_r, state_nxt;
  logic                     op_r;
  logic [WORD_W-1:0]        key_r;
  logic [ACT_W-1:0]         act_r;
  logic signed [WORD_W-1:0] arg_r;
  logic [WORD_W-1:0]        prod_r;
  slot_idx_t                pos_r, pos_nxt;
  slot_idx_t                cnt_r, cnt_nxt;
  logic [SLOT_COUNT-1:0]    valid_r;
  logic                     vld_q_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      status_r;
  logic [ACT_W-1:0]         found_act_r;
  logic signed [WORD_W-1:0] found_arg_r;

  slot_idx_t home;
  slot_idx_t rd_addr;
  slot_t     rd_data;
  slot_t     wr_data;
  logic      wr_en;
  logic      slot_empty;
  logic      key_hit;
  logic      last;
  logic      done;
  logic      out_free;
  logic      fire;
  logic      accept;

  lpht_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en),
    .waddr (pos_r),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign accept     = in_ch.valid && in_ch.ready;
  assign home       = prod_r[WORD_W-1 -: INDEX_BITS];
  assign slot_empty = !vld_q_r || (rd_data.action == '0);
  assign key_hit    = !slot_empty && (rd_data.key == key_r);
  assign last       = (cnt_r == SLOT_MASK);
  assign done       = (op_r == OP_INSERT) ? (slot_empty || last)
                                          : (slot_empty || key_hit || last);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign fire       = (state_r == ST_PROBE) && done && out_free;
  assign wr_en      = fire && (op_r == OP_INSERT) && slot_empty;
  assign wr_data    = '{key: key_r, action: act_r, arg: arg_r};

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.found_action = found_act_r;
  assign out_ch.found_arg    = found_arg_r;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    rd_addr   = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        rd_addr   = home;
        pos_nxt   = home;
        cnt_nxt   = '0;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (!done) begin
          // speculative read of the next slot; no writes happen mid-probe
          rd_addr = pos_r + 1'b1;
          pos_nxt = pos_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        valid_r[pos_r] <= 1'b1;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.op;
      key_r <= in_ch.key;
      act_r <= in_ch.action_code;
      arg_r <= in_ch.arg_value;
    end
    prod_r  <= WORD_W'(key_r * HASH_MULT);
    pos_r   <= pos_nxt;
    cnt_r   <= cnt_nxt;
    vld_q_r <= valid_r[rd_addr];
    if (fire) begin
      if (op_r == OP_INSERT) begin
        status_r    <= slot_empty ? STAT_INSERTED : STAT_FULL;
        found_act_r <= '0;
        found_arg_r <= '0;
      end else if (key_hit) begin
        status_r    <= STAT_HIT;
        found_act_r <= rd_data.action;
        found_arg_r <= rd_data.arg;
      end else begin
        status_r    <= STAT_MISS;
        found_act_r <= '0;
        found_arg_r <= '0;
      end
    end
  end

  `LPHT_ASSERT_NXT(a_accept_hash, accept, state_r == ST_HASH)
  `LPHT_ASSERT_IMP(a_probe_bound, (state_r == ST_PROBE) && (cnt_r == SLOT_MASK), done)
  `LPHT_ASSERT_IMP(a_write_empty, wr_en, (op_r == OP_INSERT) && slot_empty && out_free)
  `LPHT_ASSERT_NXT(a_fire_result, fire, out_valid_r && (state_r == ST_IDLE))
  `LPHT_ASSERT_IMP(a_hit_action, out_valid_r && (status_r == STAT_HIT), found_act_r != '0)

endmodule

`default_nettype wire

### bench/tb.sv
`default_nettype none

module tb;
  import lpht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = SLOT_COUNT + 10;
  localparam int MAX_REPORTS    = 100;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic [ACT_W-1:0]         found_action;
    logic signed [WORD_W-1:0] found_arg;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n;

  lpht_in_if  in_ch ();
  lpht_out_if out_ch ();

  linear_probe_hash_table DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table
  logic [ACT_W-1:0]         shadow_action [SLOT_COUNT];
  logic [WORD_W-1:0]        shadow_key    [SLOT_COUNT];
  logic signed [WORD_W-1:0] shadow_arg    [SLOT_COUNT];
  int                       occupied;

  table_result_t     pending_results [$];
  logic [WORD_W-1:0] stored_keys [$];

  int  errors;
  int  items_sent;
  int  results_checked;
  int  n_inserted, n_dropped, n_hits, n_misses;
  int  burst_left;
  bit  gaps_en;
  bit  stall_en;
  bit  hold_req;

  function automatic slot_idx_t home_of(input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] prod;
    prod = k * HASH_MULT;
    return prod[WORD_W-1 -: INDEX_BITS];
  endfunction

  function automatic table_result_t table_apply(input logic op,
                                                input logic [WORD_W-1:0] k,
                                                input logic [ACT_W-1:0] act,
                                                input logic signed [WORD_W-1:0] arg);
    table_result_t r;
    slot_idx_t     pos;
    int            n;
    bit            done;
    pos = home_of(k);
    n = 0;
    done = 1'b0;
    r.found_action = '0;
    r.found_arg = '0;
    if (op == OP_INSERT) begin
      r.status = STAT_FULL;
      while (!done && n < SLOT_COUNT) begin
        if (shadow_action[pos] == '0) begin
          shadow_key[pos] = k;
          shadow_action[pos] = act;
          shadow_arg[pos] = arg;
          if (act != '0) occupied++;
          r.status = STAT_INSERTED;
          done = 1'b1;
        end else begin
          pos++;
          n++;
        end
      end
      if (r.status == STAT_INSERTED) begin
        n_inserted++;
        stored_keys.push_back(k);
      end else begin
        n_dropped++;
      end
    end else begin
      r.status = STAT_MISS;
      while (!done && n < SLOT_COUNT) begin
        if (shadow_action[pos] == '0) begin
          done = 1'b1;
        end else if (shadow_key[pos] == k) begin
          r.status = STAT_HIT;
          r.found_action = shadow_action[pos];
          r.found_arg = shadow_arg[pos];
          done = 1'b1;
        end else begin
          pos++;
          n++;
        end
      end
      if (r.status == STAT_HIT) n_hits++;
      else n_misses++;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] key_with_home(input slot_idx_t s);
    logic [WORD_W-1:0] k;
    k = $urandom;
    while (home_of(k) != s) k = $urandom;
    return k;
  endfunction

  function automatic logic [WORD_W-1:0] pick_known_key();
    if (stored_keys.size() == 0) return $urandom;
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  task automatic send_item(input logic op, input logic [WORD_W-1:0] k,
                           input logic [ACT_W-1:0] act, input logic signed [WORD_W-1:0] arg);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_en ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.key         <= k;
    in_ch.action_code <= act;
    in_ch.arg_value   <= arg;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(table_apply(op, k, act, arg));
    items_sent++;
  endtask

  task automatic do_insert(input logic [WORD_W-1:0] k, input logic [ACT_W-1:0] act,
                           input logic signed [WORD_W-1:0] arg);
    send_item(OP_INSERT, k, act, arg);
  endtask

  // action and argument are don't-care on a lookup, so keep them random
  task automatic do_lookup(input logic [WORD_W-1:0] k);
    send_item(OP_LOOKUP, k, ACT_W'($urandom), $urandom);
  endtask

  task automatic random_insert();
    logic [WORD_W-1:0] k;
    logic [ACT_W-1:0]  act;
    k = ($urandom_range(0, 3) == 0) ? pick_known_key() : $urandom;
    act = ($urandom_range(0, 7) == 0) ? '0 : ACT_W'($urandom_range(1, 255));
    do_insert(k, act, $urandom);
  endtask

  task automatic random_lookup();
    do_lookup(($urandom_range(0, 9) < 6) ? pick_known_key() : $urandom);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_table();
    do_lookup(32'h0000_0000);
    do_lookup(32'hFFFF_FFFF);
    wait_all_results();
  endtask

  task automatic test_insert_lookup();
    do_insert(32'h0000_0000, 8'hFF, 32'sh7FFF_FFFF);
    do_insert(32'hFFFF_FFFF, 8'h01, 32'sh8000_0000);
    do_lookup(32'h0000_0000);
    do_lookup(32'hFFFF_FFFF);
    do_lookup(32'h1234_5678);
    wait_all_results();
  endtask

  // an insert with action zero leaves the slot empty, so the key is not found
  task automatic test_zero_action_insert();
    logic [WORD_W-1:0] k;
    k = $urandom;
    do_insert(k, '0, $urandom);
    do_lookup(k);
    wait_all_results();
  endtask

  // cluster at the last slot: probes wrap to slot 0; duplicate returns first entry
  task automatic test_wraparound();
    logic [WORD_W-1:0] ka, kb, kc, kd;
    ka = key_with_home(slot_idx_t'(SLOT_COUNT - 1));
    kb = key_with_home(slot_idx_t'(SLOT_COUNT - 1));
    kc = key_with_home(slot_idx_t'(SLOT_COUNT - 1));
    kd = key_with_home(slot_idx_t'(SLOT_COUNT - 1));
    do_insert(ka, 8'h11, $urandom);
    do_insert(kb, 8'h22, $urandom);
    do_insert(kc, 8'h33, $urandom);
    do_insert(ka, 8'h44, $urandom);
    do_lookup(ka);
    do_lookup(kc);
    do_lookup(kd);
    wait_all_results();
  endtask

  task automatic test_backpressure();
    int i;
    gaps_en = 1'b0;
    hold_req = 1'b1;
    for (i = 0; i < 24; i++) begin
      if (i % 3 == 0) random_insert();
      else random_lookup();
    end
    wait_all_results();
    gaps_en = 1'b1;
  endtask

  task automatic test_random_traffic(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        gaps_en = ($urandom_range(0, 2) != 0);
        stall_en = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 99) < 8) random_insert();
      else random_lookup();
    end
    wait_all_results();
    gaps_en = 1'b1;
    stall_en = 1'b1;
  endtask

  task automatic test_full_table();
    int i;
    while (occupied < SLOT_COUNT) do_insert($urandom, ACT_W'($urandom_range(1, 255)), $urandom);
    do_insert($urandom, 8'hFF, $urandom);
    do_insert(32'h0000_0000, '0, 32'sh7FFF_FFFF);
    do_insert(pick_known_key(), 8'h01, 32'sh8000_0000);
    for (i = 0; i < 30; i++) begin
      if (i % 3 == 0) do_lookup($urandom);
      else do_lookup(pick_known_key());
    end
    wait_all_results();
  endtask

  initial begin : receiver
    logic [15:0] pattern;
    int          epoch;
    out_ch.ready = 1'b0;
    pattern = '1;
    epoch = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (epoch == 0) begin
        pattern = 16'($urandom);
        if ($urandom_range(0, 3) == 0) pattern = '1;
        epoch = 64;
      end
      epoch--;
      out_ch.ready <= stall_en ? pattern[0] : 1'b1;
      pattern = {pattern[0], pattern[15:1]};
    end
  end

  always @(posedge clk) begin : check_results
    table_result_t exp;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result transaction status=%0d action=%h arg=%h",
                   $time, out_ch.status, out_ch.found_action, out_ch.found_arg);
      end else begin
        exp = pending_results.pop_front();
        if (out_ch.status !== exp.status) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, exp.status, out_ch.status);
        end
        if (out_ch.found_action !== exp.found_action) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: found_action mismatch expected %h actual %h",
                     $time, exp.found_action, out_ch.found_action);
        end
        if (out_ch.found_arg !== exp.found_arg) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: found_arg mismatch expected %h actual %h",
                     $time, exp.found_arg, out_ch.found_arg);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle = 0;
      else
        idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
                 $time, idle, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : main
    int i;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_INSERT;
    in_ch.key = '0;
    in_ch.action_code = '0;
    in_ch.arg_value = '0;
    for (i = 0; i < SLOT_COUNT; i++) begin
      shadow_action[i] = '0;
      shadow_key[i] = '0;
      shadow_arg[i] = '0;
    end
    occupied = 0;
    errors = 0;
    items_sent = 0;
    results_checked = 0;
    n_inserted = 0;
    n_dropped = 0;
    n_hits = 0;
    n_misses = 0;
    burst_left = 0;
    gaps_en = 1'b1;
    stall_en = 1'b1;
    hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_insert_lookup();
    test_zero_action_insert();
    test_wraparound();
    test_backpressure();
    test_random_traffic(1800);
    test_full_table();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) errors++;
    $display("Sent %0d transactions, checked %0d results; table filled to %0d of %0d slots.",
             items_sent, results_checked, occupied, SLOT_COUNT);
    $display("Inserts %0d, dropped on full table %0d, lookup hits %0d, lookup misses %0d.",
             n_inserted, n_dropped, n_hits, n_misses);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
